// File: sv/stable_merge_sorter_defines.svh
// Assertion macros for the stable merge sorter.
`ifndef STABLE_MERGE_SORTER_DEFINES_SVH
`define STABLE_MERGE_SORTER_DEFINES_SVH
// Check a property on every clock edge outside reset.
`define SMS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property including reset cycles.
`define SMS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: sv/sms_pkg.sv
// Package with payload types and constants of the stable merge sorter.
package sms_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W = 32;
    localparam int TAG_W = 32;
    localparam int REC_W = KEY_W + TAG_W;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic                    batch_end;
    } in_word_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0]        sorted_tag;
        logic                    final_res;
        logic                    overflowed;
    } out_word_t;

    // Record handed from front end to back end.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } rec_t;

    // Signed key compare a <= b.
    function automatic logic key_le(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return $signed(a) <= $signed(b);
    endfunction
endpackage

// File: sv/sms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/sms_front.sv
// Front end: accept input words and push records into a short queue.
module sms_front #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sms_pkg::in_word_t s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output sms_pkg::rec_t     q_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sms_pkg::rec_t  fifo_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;
    logic           push, pop;

    assign s_ready = (cnt_reg != CW'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= '{key: s_data.key, tag: s_data.tag,
                                      last: s_data.batch_end};
        end
    end
endmodule

// File: sv/sms_back.sv
// Back end: load records, run bottom-up merge passes, emit sorted words.
module sms_back #(
    parameter int CAPACITY = sms_pkg::CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  sms_pkg::rec_t      q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sms_pkg::out_word_t m_data
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = sms_pkg::REC_W;

    typedef enum logic [3:0] {
        S_LOAD, S_PASS, S_RD, S_RDW, S_CMP, S_CPY, S_CPYW, S_EMIT_RD, S_EMIT_W, S_EMIT
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  fill_reg, n_reg;
    logic           drop_reg;
    logic [CW:0]    width_reg, lo_reg, mid_reg, hi_reg, i_reg, j_reg, k_reg;
    logic           rd_side_reg;   // 0: reading left run, 1: right run
    logic [RW-1:0]  a_reg, b_reg;
    logic           a_ok_reg, b_ok_reg;
    logic           emit_last_reg;

    // Store and scratch RAMs.
    logic           st_we, sc_we;
    logic [AW-1:0]  st_wa, st_ra, sc_wa, sc_ra;
    logic [RW-1:0]  st_wd, st_rd, sc_wd, sc_rd;

    sms_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_store (
        .aclk(aclk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd)
    );
    sms_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_scratch (
        .aclk(aclk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd)
    );

    logic take_a;
    logic [CW:0] hi_calc;
    assign take_a = a_ok_reg && (!b_ok_reg ||
                    sms_pkg::key_le(a_reg[RW-1 -: sms_pkg::KEY_W],
                                    b_reg[RW-1 -: sms_pkg::KEY_W]));
    assign hi_calc = (lo_reg + (width_reg << 1) < (CW+1)'(n_reg)) ?
                     lo_reg + (width_reg << 1) : (CW+1)'(n_reg);

    assign q_ready = (state_reg == S_LOAD);

    always_comb begin
        st_we = 1'b0;
        st_wa = fill_reg[AW-1:0];
        st_wd = {q_data.key, q_data.tag};
        st_ra = (rd_side_reg) ? j_reg[AW-1:0] : i_reg[AW-1:0];
        sc_we = 1'b0;
        sc_wa = k_reg[AW-1:0];
        sc_wd = take_a ? a_reg : b_reg;
        sc_ra = k_reg[AW-1:0];
        if (state_reg == S_LOAD && q_valid && fill_reg != CW'(CAPACITY)) begin
            st_we = 1'b1;
        end
        if (state_reg == S_CMP) begin
            sc_we = 1'b1;
        end
        if (state_reg == S_CPYW) begin
            st_we = 1'b1;
            st_wa = k_reg[AW-1:0];
            st_wd = sc_rd;
        end
        if (state_reg == S_EMIT_RD) begin
            st_ra = k_reg[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
            m_valid   <= 1'b0;
            rd_side_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_LOAD: begin
                    if (q_valid) begin
                        logic [CW-1:0] nf;
                        nf = fill_reg;
                        if (fill_reg != CW'(CAPACITY)) begin
                            nf = fill_reg + 1'b1;
                        end else begin
                            drop_reg <= 1'b1;
                        end
                        fill_reg <= nf;
                        if (q_data.last) begin
                            n_reg     <= nf;
                            width_reg <= (CW+1)'(1);
                            lo_reg    <= '0;
                            state_reg <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    // Start next merge of this width, the next width, or the emit once all passes are done.
                    if (width_reg >= (CW+1)'(n_reg)) begin
                        k_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end else if (lo_reg + width_reg >= (CW+1)'(n_reg)) begin
                        width_reg <= width_reg << 1;
                        lo_reg    <= '0;
                    end else begin
                        mid_reg <= lo_reg + width_reg;
                        hi_reg  <= hi_calc;
                        i_reg   <= lo_reg;
                        j_reg   <= lo_reg + width_reg;
                        k_reg   <= lo_reg;
                        rd_side_reg <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    state_reg <= S_RDW;
                end
                S_RDW: begin
                    if (!rd_side_reg) begin
                        a_reg    <= st_rd;
                        a_ok_reg <= (i_reg < mid_reg);
                        rd_side_reg <= 1'b1;
                        state_reg <= S_RD;
                    end else begin
                        b_reg    <= st_rd;
                        b_ok_reg <= (j_reg < hi_reg);
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    // Write the smaller head (the left one on equal keys), then refill the heads.
                    if (k_reg + 1'b1 == hi_reg) begin
                        k_reg     <= lo_reg;
                        state_reg <= S_CPY;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                    if (take_a) begin
                        i_reg <= i_reg + 1'b1;
                        rd_side_reg <= 1'b0;
                        j_reg <= j_reg;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                        rd_side_reg <= 1'b1;
                    end
                    // Taking the right head refetches only the right side; taking the left refetches both heads.
                    if (take_a) begin
                        b_reg <= b_reg;
                    end
                end
                S_CPY: begin
                    state_reg <= S_CPYW;
                end
                S_CPYW: begin
                    if (k_reg + 1'b1 == hi_reg) begin
                        lo_reg    <= lo_reg + (width_reg << 1);
                        state_reg <= S_PASS;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_CPY;
                    end
                end
                S_EMIT_RD: begin
                    state_reg <= S_EMIT_W;
                end
                S_EMIT_W: begin
                    m_data.sorted_key <= st_rd[RW-1 -: sms_pkg::KEY_W];
                    m_data.sorted_tag <= st_rd[sms_pkg::TAG_W-1:0];
                    m_data.final_res  <= (k_reg + 1'b1 == (CW+1)'(n_reg));
                    m_data.overflowed <= drop_reg;
                    emit_last_reg     <= (k_reg + 1'b1 == (CW+1)'(n_reg));
                    m_valid           <= 1'b1;
                    state_reg         <= S_EMIT;
                end
                S_EMIT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        if (emit_last_reg) begin
                            fill_reg  <= '0;
                            drop_reg  <= 1'b0;
                            state_reg <= S_LOAD;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule

// File: sv/stable_merge_sorter.sv
// Top level of the stable merge sorter: front queue plus sort/emit engine.
//
// Usage: records arrive on the s_ channel (s_valid/s_ready, payload s_data
// with key, tag, batch_end), one record per word. A word with batch_end set
// closes the batch. Up to CAPACITY records are stored; further records are
// dropped and every result of that batch carries overflowed = 1.
// After the closing word the engine sorts the batch ascending by signed key,
// stable on equal keys, using bottom-up merge passes through a scratch RAM.
// Loading takes one word per cycle while the queue holds words. A merged
// element takes longer when the left head is taken than when the right
// one is (the refill reads both heads again); each merged run is then
// copied back from the scratch RAM, and each merge starts by reading both
// heads. Sorted words leave one at a time on the m_ channel (m_valid/
// m_ready, payload m_data). The store RAM has a single read port, so the
// heads are read one after the other. final_res marks the last sorted word.
// A two-entry queue lets the front accept words while the engine is busy;
// the engine takes no new record until the batch is emitted.
// Reset (aresetn low, synchronous) empties the queue and the batch; stored
// data is not cleared. When the receiver stalls, m_data holds and the
// engine waits; the front then fills its queue and drops s_ready.
`include "stable_merge_sorter_defines.svh"
module stable_merge_sorter #(
    parameter int CAPACITY = sms_pkg::CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sms_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sms_pkg::out_word_t m_data
);
    logic          q_valid, q_ready;
    sms_pkg::rec_t q_data;

    // Front: accept words into the queue.
    sms_front #(.DEPTH(2)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    // Back: load, sort, emit.
    sms_back #(.CAPACITY(CAPACITY)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // No result word is offered while the engine still takes records.
    `SMS_ASSERT(a_no_emit_while_load, aclk, aresetn, !(m_valid && q_ready), "emit during load")
    // Valid output comes out of reset low.
    `SMS_ASSERT_ALWAYS(a_reset_quiet, aclk, !$past(aresetn) |-> !m_valid, "m_valid after reset")
    // A stalled result word holds its payload.
    `SMS_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_data), "m_data moved")
endmodule
